// ===== src/min_priority_queue_top_defines.svh =====
// Assertion macros used by the priority queue RTL.
`ifndef MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define MIN_PRIORITY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Antecedent implies consequent in the same cycle.
`define MPQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define MPQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define MPQ_ASSERT_IMP(name, clk, rst, ante, cons)
`define MPQ_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== src/mpq_pkg.sv =====
package mpq_pkg;

   localparam int DEPTH     = 256;
   localparam int TAG_BITS  = 9;
   localparam int FREQ_BITS = 32;

   typedef enum logic [0:0] {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_ENQUEUED = 2'd0,
      ST_DEQUEUED = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_DROPPED  = 2'd3
   } status_type;

   typedef struct packed {
      logic [FREQ_BITS-1:0] freq;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // Broadcast to every cell
   typedef struct packed {
      logic      enq;
      logic      deq;
      entry_type entry;
   } cmd_type;

   // What a cell shows its neighbors
   typedef struct packed {
      entry_type entry;
      logic      valid;
      logic      after;  // new entry belongs at or before this cell
   } link_type;

endpackage

// ===== src/min_priority_queue_top.sv =====
// The result word appears on the rsp_ ports in the cycle after start is taken.
// Throughput: one item per cycle; busy stays low, since every cell of the
// sorted chain compares against the new key and shifts in that same cycle.
// The receiver cannot stall; each result is strobed by rsp_valid for one cycle.
// Reset (synchronous, active high) empties the queue.
`include "min_priority_queue_top_defines.svh"

module min_priority_queue_top
   import mpq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic                 req_op,
   input  logic [FREQ_BITS-1:0] req_item_frequency,
   input  logic [TAG_BITS-1:0]  req_item_tag,
   output logic                 rsp_valid,
   output logic [1:0]           rsp_status,
   output logic [FREQ_BITS-1:0] rsp_out_frequency,
   output logic [TAG_BITS-1:0]  rsp_out_tag,
   output logic                 rsp_now_empty
);

   link_type   cell_link  [DEPTH];
   link_type   left_link  [DEPTH];
   link_type   right_link [DEPTH];
   link_type   head_link;
   link_type   tail_link;
   cmd_type    cmd;
   logic       accept;
   logic       is_deq;
   logic       queue_empty;
   logic       queue_full;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   status_type           rsp_status_in;
   logic [FREQ_BITS-1:0] rsp_freq_ff;
   logic [FREQ_BITS-1:0] rsp_freq_in;
   logic [TAG_BITS-1:0]  rsp_tag_ff;
   logic [TAG_BITS-1:0]  rsp_tag_in;
   logic                 rsp_empty_ff;
   logic                 rsp_empty_in;

   assign busy        = 1'b0;
   assign accept      = start && !busy;
   assign is_deq      = (op_type'(req_op) == OP_DEQUEUE);
   assign queue_empty = !cell_link[0].valid;
   assign queue_full  = cell_link[DEPTH-1].valid;

   // Broadcast command; drop enqueue on full and dequeue on empty
   assign cmd.enq         = accept && !is_deq && !queue_full;
   assign cmd.deq         = accept && is_deq && !queue_empty;
   assign cmd.entry.freq  = req_item_frequency;
   assign cmd.entry.tag   = req_item_tag;

   // Chain ends: nothing goes before the head, nothing valid past the tail
   assign head_link.entry = '0;
   assign head_link.valid = 1'b1;
   assign head_link.after = 1'b0;
   assign tail_link.entry = '0;
   assign tail_link.valid = 1'b0;
   assign tail_link.after = 1'b1;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign left_link[i] = head_link;
      end else begin : g_mid_l
         assign left_link[i] = cell_link[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign right_link[i] = tail_link;
      end else begin : g_mid_r
         assign right_link[i] = cell_link[i+1];
      end

      mpq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .is_head    (i == 0),
         .cmd        (cmd),
         .left_link  (left_link[i]),
         .right_link (right_link[i]),
         .cell_link  (cell_link[i])
      );
   end

   // Form the result word from the state before the update
   always_comb begin
      rsp_freq_in = '0;
      rsp_tag_in  = '0;
      if (is_deq) begin
         if (queue_empty) begin
            rsp_status_in = ST_EMPTY;
            rsp_empty_in  = 1'b1;
         end else begin
            rsp_status_in = ST_DEQUEUED;
            rsp_freq_in   = cell_link[0].entry.freq;
            rsp_tag_in    = cell_link[0].entry.tag;
            rsp_empty_in  = !cell_link[1].valid;
         end
      end else begin
         rsp_status_in = queue_full ? ST_DROPPED : ST_ENQUEUED;
         rsp_empty_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            rsp_status_ff <= rsp_status_in;
            rsp_freq_ff   <= rsp_freq_in;
            rsp_tag_ff    <= rsp_tag_in;
            rsp_empty_ff  <= rsp_empty_in;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_out_frequency = rsp_freq_ff;
   assign rsp_out_tag       = rsp_tag_ff;
   assign rsp_now_empty     = rsp_empty_ff;

   // Occupied cells form a prefix kept in nondecreasing key order
   for (genvar j = 0; j < DEPTH - 1; j++) begin : g_chk
      `MPQ_ASSERT_IMP(a_sorted_prefix, clock, reset, cell_link[j+1].valid,
         cell_link[j].valid && (cell_link[j].entry.freq <= cell_link[j+1].entry.freq))
   end

   `MPQ_ASSERT_NXT(a_strobe_follows, clock, reset, accept, rsp_valid)
   `MPQ_ASSERT_NXT(a_no_spurious, clock, reset, !accept, !rsp_valid)
   `MPQ_ASSERT_IMP(a_drop_full, clock, reset, rsp_valid && (rsp_status == ST_DROPPED),
      queue_full)
   `MPQ_ASSERT_NXT(a_deq_head, clock, reset, cmd.deq,
      rsp_out_frequency == $past(cell_link[0].entry.freq))

endmodule

// ===== src/mpq_cell.sv =====
module mpq_cell
   import mpq_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     is_head,
   input  cmd_type  cmd,
   input  link_type left_link,
   input  link_type right_link,
   output link_type cell_link
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      valid_ff;
   logic      valid_in;
   logic      after;

   // Head takes the new word only on a strictly smaller key; others on ties too
   always_comb begin
      if (!valid_ff) begin
         after = 1'b1;
      end else if (is_head) begin
         after = cmd.entry.freq < entry_ff.freq;
      end else begin
         after = cmd.entry.freq <= entry_ff.freq;
      end
   end

   // Insert, shift right on enqueue, shift left on dequeue, else hold
   always_comb begin
      entry_in = entry_ff;
      valid_in = valid_ff;
      if (cmd.deq) begin
         entry_in = right_link.entry;
         valid_in = right_link.valid;
      end else if (cmd.enq && after) begin
         if (!left_link.after) begin
            entry_in = cmd.entry;
            valid_in = 1'b1;
         end else begin
            entry_in = left_link.entry;
            valid_in = left_link.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         entry_ff <= entry_in;
      end
   end

   assign cell_link.entry = entry_ff;
   assign cell_link.valid = valid_ff;
   assign cell_link.after = after;

endmodule
